// ===== design/ptdt_pkg.sv =====
package ptdt_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int TICK_MS_DEF   = 10;
   localparam int RESULT_CAP    = 16;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_DELETE   = 2'd1,
      OP_TICK     = 2'd2,
      OP_DISPATCH = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_ADDED   = 3'd0,
      ST_FULL    = 3'd1,
      ST_DELETED = 3'd2,
      ST_BADSLOT = 3'd3,
      ST_FIRED   = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  task_tag;
      logic [31:0] delay_ms;
      logic [31:0] period_ms;
      logic [3:0]  task_slot;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic [7:0] fired_tag;
      logic       last;
   } rsp_type;

   // Command as queued for the back end: ms already scaled to ticks.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  task_tag;
      logic [31:0] delay_ticks;
      logic [31:0] period_ticks;
      logic [3:0]  task_slot;
   } cmd_type;

   typedef enum logic [2:0] {
      FE_IDLE,
      FE_DIV_DELAY,
      FE_DIV_PERIOD,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_EXEC,
      BE_SCAN,
      BE_SHIFT,
      BE_DONE
   } be_state_type;

   typedef struct packed {
      logic queue_empty;
      logic back_idle;
   } stat_type;

endpackage

// ===== design/ptdt_front.sv =====
module ptdt_front #(
   parameter int TICK_MS = ptdt_pkg::TICK_MS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ptdt_pkg::req_type req,
   output logic              busy_front,
   input  logic              q_full,
   output logic              push,
   output ptdt_pkg::cmd_type push_cmd
);
   import ptdt_pkg::*;

   fe_state_type state_ff, state_in;
   req_type      req_ff, req_in;
   logic [31:0]  quot_ff, quot_in;
   logic [31:0]  dq_ff, dq_in;
   logic [65:0]  acc_ff, acc_in;
   logic         half_ff, half_in;
   logic [15:0]  part;
   logic [49:0]  prod;
   logic [65:0]  sum;
   logic [31:0]  quot;

   localparam int          ShiftAmt = 32 + $clog2(TICK_MS);
   localparam logic [65:0] Pow2     = 66'(1) << ShiftAmt;
   localparam logic [33:0] Recip    = 34'((Pow2 + 66'(TICK_MS - 1)) / 66'(TICK_MS));

   // Divide by the tick length as a multiply by its rounded-up reciprocal;
   // take 16 bits of the dividend per cycle, low half first.
   always_comb begin
      unique case (state_ff)
         FE_DIV_DELAY:  part = half_ff ? req_ff.delay_ms[31:16] : req_ff.delay_ms[15:0];
         FE_DIV_PERIOD: part = half_ff ? req_ff.period_ms[31:16] : req_ff.period_ms[15:0];
         default:       part = 16'd0;
      endcase
      prod = 50'(part) * 50'(Recip);
      sum  = half_ff ? acc_ff + {prod, 16'd0} : 66'(prod);
      quot = 32'(sum >> ShiftAmt);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FE_IDLE:       if (start) state_in = FE_DIV_DELAY;
         FE_DIV_DELAY:  if (half_ff) state_in = FE_DIV_PERIOD;
         FE_DIV_PERIOD: if (half_ff) state_in = FE_PUSH;
         FE_PUSH:       if (!q_full) state_in = FE_IDLE;
         default:       state_in = FE_IDLE;
      endcase
   end

   always_comb begin
      req_in  = req_ff;
      quot_in = quot_ff;
      dq_in   = dq_ff;
      acc_in  = acc_ff;
      half_in = half_ff;
      unique case (state_ff)
         FE_IDLE: begin
            req_in  = req;
            half_in = 1'b0;
         end
         FE_DIV_DELAY, FE_DIV_PERIOD: begin
            acc_in  = sum;
            half_in = !half_ff;
            if (half_ff) begin
               if (state_ff == FE_DIV_DELAY) dq_in = quot;
               else                          quot_in = quot;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FE_IDLE;
      else       state_ff <= state_in;
      req_ff  <= req_in;
      quot_ff <= quot_in;
      dq_ff   <= dq_in;
      acc_ff  <= acc_in;
      half_ff <= half_in;
   end

   always_comb begin
      busy_front            = (state_ff != FE_IDLE);
      push                  = (state_ff == FE_PUSH) && !q_full;
      push_cmd.opcode       = req_ff.opcode;
      push_cmd.task_tag     = req_ff.task_tag;
      push_cmd.delay_ticks  = dq_ff;
      push_cmd.period_ticks = quot_ff;
      push_cmd.task_slot    = req_ff.task_slot;
   end

endmodule

// ===== design/ptdt_queue.sv =====
module ptdt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptdt_pkg::cmd_type push_cmd,
   input  logic              pop,
   output ptdt_pkg::cmd_type pop_cmd,
   output logic              full,
   output logic              empty
);
   import ptdt_pkg::*;

   cmd_type    mem_ff [QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      full   = (cnt_ff == 2'(QUEUE_DEPTH));
      empty  = (cnt_ff == 2'd0);
      pop_cmd = mem_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= push_cmd;
   end

endmodule

// ===== design/ptdt_back.sv =====
module ptdt_back #(
   parameter int MAX_TASKS = ptdt_pkg::MAX_TASKS_DEF,
   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
   localparam int CW = $clog2(MAX_TASKS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  ptdt_pkg::cmd_type cmd,
   output logic              pop,
   output logic              idle,
   output logic              rsp_valid,
   output ptdt_pkg::rsp_type rsp
);
   import ptdt_pkg::*;

   be_state_type state_ff, state_in;
   cmd_type      cmd_ff, cmd_in;
   logic [31:0]  tick_ff, tick_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;      // scan position
   logic [CW-1:0] sh_ff, sh_in;        // shift position
   logic [4:0]   nres_ff, nres_in;
   logic         fromscan_ff, fromscan_in;
   logic         pend_ff, pend_in;     // a fired result waits for last flag
   rsp_type      pres_ff, pres_in;
   logic         ov_ff, ov_in;
   rsp_type      ores_ff, ores_in;

   logic [31:0]  due_mem   [MAX_TASKS];
   logic [31:0]  per_mem   [MAX_TASKS];
   logic [7:0]   tag_mem   [MAX_TASKS];

   logic [IW-1:0] ri, si, si1, wi;
   logic [31:0]   cur_due, cur_per, diff;
   logic [7:0]    cur_tag;
   logic          wr_en;
   logic [31:0]   wr_due, wr_per;
   logic [7:0]    wr_tag;
   logic          scan_more, due_now;

   always_comb begin
      ri  = idx_ff[IW-1:0];
      si  = sh_ff[IW-1:0];
      si1 = IW'(sh_ff + CW'(1));
      cur_due = due_mem[ri];
      cur_per = per_mem[ri];
      cur_tag = tag_mem[ri];
      diff    = tick_ff - cur_due;
      due_now = !diff[31];
      scan_more = (idx_ff < count_ff) && (nres_ff < 5'(RESULT_CAP));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BE_IDLE: if (!q_empty) state_in = BE_EXEC;
         BE_EXEC: begin
            unique case (opcode_type'(cmd_ff.opcode))
               OP_DELETE:   state_in = ({1'b0, cmd_ff.task_slot} < 5'(count_ff)
                                        || CW > 5) &&
                                       (CW'(cmd_ff.task_slot) < count_ff)
                                       ? BE_SHIFT : BE_IDLE;
               OP_DISPATCH: state_in = BE_SCAN;
               default:     state_in = BE_IDLE;
            endcase
         end
         BE_SCAN: begin
            if (!scan_more) state_in = BE_DONE;
            else if (due_now && cur_per == 32'd0) state_in = BE_SHIFT;
         end
         BE_SHIFT: if (sh_ff + CW'(1) >= count_ff)
                      state_in = fromscan_ff ? BE_SCAN : BE_IDLE;
         BE_DONE:  state_in = BE_IDLE;
         default:  state_in = BE_IDLE;
      endcase
   end

   always_comb begin
      cmd_in = cmd_ff; tick_in = tick_ff; count_in = count_ff;
      idx_in = idx_ff; sh_in = sh_ff; nres_in = nres_ff;
      fromscan_in = fromscan_ff; pend_in = pend_ff; pres_in = pres_ff;
      ov_in = 1'b0; ores_in = ores_ff;
      pop = 1'b0;
      wr_en = 1'b0; wi = ri; wr_due = cur_due; wr_per = cur_per; wr_tag = cur_tag;
      unique case (state_ff)
         BE_IDLE: if (!q_empty) begin
            pop = 1'b1; cmd_in = cmd;
         end
         BE_EXEC: begin
            idx_in = '0; nres_in = 5'd0; pend_in = 1'b0;
            unique case (opcode_type'(cmd_ff.opcode))
               OP_ADD: begin
                  ov_in = 1'b1;
                  ores_in.last = 1'b1; ores_in.fired_tag = 8'd0;
                  if (count_ff >= CW'(MAX_TASKS)) begin
                     ores_in.status = ST_FULL; ores_in.slot = 4'd0;
                  end else begin
                     ores_in.status = ST_ADDED; ores_in.slot = 4'(count_ff);
                     wr_en = 1'b1; wi = count_ff[IW-1:0];
                     wr_due = tick_ff + cmd_ff.delay_ticks;
                     wr_per = cmd_ff.period_ticks; wr_tag = cmd_ff.task_tag;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_DELETE: begin
                  ov_in = 1'b1;
                  ores_in.last = 1'b1; ores_in.fired_tag = 8'd0;
                  ores_in.slot = cmd_ff.task_slot;
                  if (CW'(cmd_ff.task_slot) < count_ff && {1'b0, cmd_ff.task_slot} <
                      5'(count_ff) || (CW > 5 && CW'(cmd_ff.task_slot) < count_ff)) begin
                     ores_in.status = ST_DELETED;
                     sh_in = CW'(cmd_ff.task_slot); fromscan_in = 1'b0;
                  end else ores_in.status = ST_BADSLOT;
               end
               OP_TICK: tick_in = tick_ff + 32'd1;
               default: ;
            endcase
         end
         BE_SCAN: if (scan_more && due_now) begin
            if (pend_ff) begin ov_in = 1'b1; ores_in = pres_ff; end
            pend_in = 1'b1;
            pres_in.status = ST_FIRED; pres_in.slot = 4'(idx_ff);
            pres_in.fired_tag = cur_tag; pres_in.last = 1'b0;
            nres_in = nres_ff + 5'd1;
            if (cur_per != 32'd0) begin
               wr_en = 1'b1; wr_due = cur_due + cur_per;
               idx_in = idx_ff + CW'(1);
            end else begin
               sh_in = idx_ff; fromscan_in = 1'b1;
            end
         end else if (scan_more) idx_in = idx_ff + CW'(1);
         BE_SHIFT: begin
            if (sh_ff + CW'(1) < count_ff) begin
               wr_en = 1'b1; wi = si;
               wr_due = due_mem[si1]; wr_per = per_mem[si1]; wr_tag = tag_mem[si1];
               sh_in = sh_ff + CW'(1);
            end else count_in = count_ff - CW'(1);
         end
         BE_DONE: if (pend_ff) begin
            ov_in = 1'b1; ores_in = pres_ff; ores_in.last = 1'b1; pend_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE; tick_ff <= 32'd0; count_ff <= '0;
         ov_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; tick_ff <= tick_in; count_ff <= count_in;
         ov_ff <= ov_in; pend_ff <= pend_in;
      end
      cmd_ff <= cmd_in; idx_ff <= idx_in; sh_ff <= sh_in; nres_ff <= nres_in;
      fromscan_ff <= fromscan_in; pres_ff <= pres_in; ores_ff <= ores_in;
      if (wr_en) begin
         due_mem[wi] <= wr_due; per_mem[wi] <= wr_per; tag_mem[wi] <= wr_tag;
      end
   end

   always_comb begin
      idle      = (state_ff == BE_IDLE) && !ov_ff;
      rsp_valid = ov_ff;
      rsp       = ores_ff;
   end

endmodule

// ===== design/periodic_task_dispatch_table_core.sv =====
// Periodic task dispatch table.
// Request channel: drive req with start high; the beat is taken on a clock
// edge where busy is low. Opcodes: add, delete, tick, dispatch.
// Response channel: each result beat shows on rsp for one cycle with
// rsp_valid high; the receiver cannot stall, so results never wait.
// Add and delete give one beat with last set; tick gives none; dispatch
// gives one beat per due task (at most 16), the final one with last set.
// The front end scales delay and period from ms to ticks by a reciprocal
// multiply, 16 bits per cycle, then pushes into a two-entry queue; the back
// end pops and executes. An add or delete beat is registered in the back
// end's exec state, and busy stays high while it shows. A delete keeps busy
// high while the table compacts one entry per cycle. Dispatch scans one
// entry per cycle while no compaction is running, each one-shot removal
// compacts the tail the same way, and the last beat is issued from the
// done state once the scan ends.
// busy stays high from acceptance until the whole command has drained, so a
// new request always finds a settled table.
// Reset clears tick counter, task count, state machines, queue pointers and
// response flags; table entries are not cleared as only live ones are read.
module periodic_task_dispatch_table_core #(
   parameter int MAX_TASKS = ptdt_pkg::MAX_TASKS_DEF,
   parameter int TICK_MS   = ptdt_pkg::TICK_MS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptdt_pkg::req_type req,
   output logic              rsp_valid,
   output ptdt_pkg::rsp_type rsp
);
   import ptdt_pkg::*;

   logic     busy_front, q_full, push, pop;
   cmd_type  push_cmd, pop_cmd;
   stat_type stat;

   ptdt_front #(.TICK_MS(TICK_MS)) u_front (
      .clock, .reset, .start(start && !busy), .req,
      .busy_front, .q_full, .push, .push_cmd
   );

   ptdt_queue u_queue (
      .clock, .reset, .push, .push_cmd, .pop, .pop_cmd,
      .full(q_full), .empty(stat.queue_empty)
   );

   ptdt_back #(.MAX_TASKS(MAX_TASKS)) u_back (
      .clock, .reset, .q_empty(stat.queue_empty), .cmd(pop_cmd), .pop,
      .idle(stat.back_idle), .rsp_valid, .rsp
   );

   // Hold off new requests until everything downstream has drained.
   assign busy = busy_front || !stat.queue_empty || !stat.back_idle;

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full)) else $error("push into full queue");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after accept");
   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status <= ST_FIRED)) else $error("bad status");
`endif

endmodule
